// ----- rtl/adt_pkg.sv -----
`timescale 1ns / 1ps
package adt_pkg;

  // internal velocity width: 1/65536 m/s with headroom for the three rotations
  localparam int VW = 34;
  // angle accumulator width, units of 2^-32 turn
  localparam int ZW = 34;
  localparam int TABLE_LEN = 24;
  // micro-steps of the square root, one result bit each
  localparam int SQ_STEPS = 32;
  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);

  // atan(2^-i) in 2^-32 turn
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    ZW'(64'sd536870912), ZW'(64'sd316933406), ZW'(64'sd167458907),
    ZW'(64'sd85004756),  ZW'(64'sd42667331),  ZW'(64'sd21354465),
    ZW'(64'sd10679838),  ZW'(64'sd5340245),   ZW'(64'sd2670163),
    ZW'(64'sd1335087),   ZW'(64'sd667544),    ZW'(64'sd333772),
    ZW'(64'sd166886),    ZW'(64'sd83443),     ZW'(64'sd41722),
    ZW'(64'sd20861),     ZW'(64'sd10430),     ZW'(64'sd5215),
    ZW'(64'sd2608),      ZW'(64'sd1304),      ZW'(64'sd652),
    ZW'(64'sd326),       ZW'(64'sd163),       ZW'(64'sd81)
  };

  // data riding alongside each rotation
  typedef struct packed {
    logic signed [VW-1:0] wz;
    logic signed [15:0]   roll;
    logic signed [15:0]   pitch;
    logic signed [19:0]   vf;
    logic signed [19:0]   vl;
    logic signed [19:0]   vu;
  } side1_t;

  typedef struct packed {
    logic signed [VW-1:0] wy;
    logic signed [15:0]   roll;
    logic signed [19:0]   vf;
    logic signed [19:0]   vl;
    logic signed [19:0]   vu;
  } side2_t;

  typedef struct packed {
    logic signed [VW-1:0] wx;
    logic signed [19:0]   vf;
    logic signed [19:0]   vl;
    logic signed [19:0]   vu;
  } side3_t;

  // flags of the atan2 special cases
  typedef struct packed {
    logic zero_x;
    logic y_pos;
    logic y_neg;
  } vflags_t;

endpackage

// ----- rtl/air_data_triplet.sv -----
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     start_i / busy_o   roll/pitch/yaw angles, vel_*, wind_*
// result    done_o (strobe)    air_speed_o, attack_angle_o, sideslip_angle_o
//
// One item may be started every cycle; busy_o never rises.
// The path runs through three rotation chains of
// CORDIC_STAGES + 2 stages, one subtract stage, two square/sum stages,
// 32 square-root cells and an output register.
// Reset clears only the valid pipe; payload registers are not reset.
// Results are shown for one cycle under done_o and cannot be held off.
module air_data_triplet #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [19:0] vel_forward_i,
  input  logic signed [19:0] vel_left_i,
  input  logic signed [19:0] vel_up_i,
  input  logic signed [19:0] wind_north_i,
  input  logic signed [19:0] wind_west_i,
  input  logic signed [19:0] wind_vertical_i,
  output logic               done_o,
  output logic [20:0]        air_speed_o,
  output logic signed [15:0] attack_angle_o,
  output logic signed [15:0] sideslip_angle_o
);

  localparam int N = CORDIC_STAGES;
  localparam int W = adt_pkg::VW;
  localparam int LAT = 3 * (N + 2) + 4 + adt_pkg::SQ_STEPS;
  localparam int DLY = adt_pkg::SQ_STEPS + 3 - (N + 2);
  localparam int S1W = $bits(adt_pkg::side1_t);
  localparam int S2W = $bits(adt_pkg::side2_t);
  localparam int S3W = $bits(adt_pkg::side3_t);

  logic                accept;
  logic [LAT-1:0]      valid_q;

  adt_pkg::side1_t     s1_in, s1_out;
  adt_pkg::side2_t     s2_in, s2_out;
  adt_pkg::side3_t     s3_out;
  logic [S1W-1:0]      s1_out_b;
  logic [S2W-1:0]      s2_out_b;
  logic [S3W-1:0]      s3_out_b;
  logic signed [W-1:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y;
  logic [31:0]         yaw_neg, roll_neg;

  logic signed [W-1:0] u_q, v_q, w_q;
  logic [63:0]         uu_q, vv_q, ww_q, sum_q;
  logic [63:0]         rem_s [0:adt_pkg::SQ_STEPS];
  logic [63:0]         res_s [0:adt_pkg::SQ_STEPS];
  logic [63:0]         mag;
  logic [20:0]         speed_q;
  logic signed [2*W-1:0] uu, vv, ww;

  logic signed [15:0]  alpha, beta;
  logic signed [15:0]  alpha_dl [0:DLY-1];
  logic signed [15:0]  beta_dl [0:DLY-1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid pipe, one bit per register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  // Rz(-yaw) on the wind
  assign yaw_neg   = {16'(16'sd0 - yaw_angle_i), 16'h0000};
  assign s1_in.wz    = W'($signed({wind_vertical_i, 8'h00}));
  assign s1_in.roll  = roll_angle_i;
  assign s1_in.pitch = pitch_angle_i;
  assign s1_in.vf    = vel_forward_i;
  assign s1_in.vl    = vel_left_i;
  assign s1_in.vu    = vel_up_i;

  adt_rotator #(.N(N), .SIDE_W(S1W)) u_rot_yaw (
    .clk_i  (clk_i),
    .x_i    (W'($signed({wind_north_i, 8'h00}))),
    .y_i    (W'($signed({wind_west_i, 8'h00}))),
    .ang_i  (yaw_neg),
    .side_i (s1_in),
    .x_o    (r1_x),
    .y_o    (r1_y),
    .side_o (s1_out_b)
  );
  assign s1_out = s1_out_b;

  // Ry(-pitch) on (x, z)
  assign s2_in.wy   = r1_y;
  assign s2_in.roll = s1_out.roll;
  assign s2_in.vf   = s1_out.vf;
  assign s2_in.vl   = s1_out.vl;
  assign s2_in.vu   = s1_out.vu;

  adt_rotator #(.N(N), .SIDE_W(S2W)) u_rot_pitch (
    .clk_i  (clk_i),
    .x_i    (r1_x),
    .y_i    (s1_out.wz),
    .ang_i  ({s1_out.pitch, 16'h0000}),
    .side_i (s2_in),
    .x_o    (r2_x),
    .y_o    (r2_y),
    .side_o (s2_out_b)
  );
  assign s2_out = s2_out_b;

  // Rx(-roll) on (y, z)
  assign roll_neg = {16'(16'sd0 - s2_out.roll), 16'h0000};

  adt_rotator #(.N(N), .SIDE_W(S3W)) u_rot_roll (
    .clk_i  (clk_i),
    .x_i    (s2_out.wy),
    .y_i    (r2_y),
    .ang_i  (roll_neg),
    .side_i ({r2_x, s2_out.vf, s2_out.vl, s2_out.vu}),
    .x_o    (r3_x),
    .y_o    (r3_y),
    .side_o (s3_out_b)
  );
  assign s3_out = s3_out_b;

  // relative velocity, FLU to FRD
  always_ff @(posedge clk_i) begin
    u_q <= W'($signed({s3_out.vf, 8'h00})) - s3_out.wx;
    v_q <= r3_x - W'($signed({s3_out.vl, 8'h00}));
    w_q <= r3_y - W'($signed({s3_out.vu, 8'h00}));
  end

  // squares, then their sum
  assign uu = (2*W)'(u_q) * (2*W)'(u_q);
  assign vv = (2*W)'(v_q) * (2*W)'(v_q);
  assign ww = (2*W)'(w_q) * (2*W)'(w_q);

  always_ff @(posedge clk_i) begin
    uu_q  <= uu[63:0];
    vv_q  <= vv[63:0];
    ww_q  <= ww[63:0];
    sum_q <= uu_q + vv_q + ww_q;
  end

  // square-root cell chain
  assign rem_s[0] = sum_q;
  assign res_s[0] = '0;

  for (genvar k = 0; k < adt_pkg::SQ_STEPS; k++) begin : g_sqrt
    adt_sqrt_cell #(.K(k)) u_sqrt (
      .clk_i (clk_i),
      .rem_i (rem_s[k]),
      .res_i (res_s[k]),
      .rem_o (rem_s[k+1]),
      .res_o (res_s[k+1])
    );
  end

  // round to 1/256 m/s and saturate
  assign mag = (res_s[adt_pkg::SQ_STEPS] + 64'd128) >> 8;

  always_ff @(posedge clk_i) begin
    speed_q <= (mag > 64'd2097151) ? 21'h1FFFFF : mag[20:0];
  end

  // alpha and beta vectoring chains
  adt_atan2 #(.N(N)) u_alpha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .y_i    (w_q),
    .x_i    (u_q),
    .ang_o  (alpha)
  );

  adt_atan2 #(.N(N)) u_beta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .y_i    (v_q),
    .x_i    (u_q),
    .ang_o  (beta)
  );

  // delay angles to line up with the root
  always_ff @(posedge clk_i) begin
    alpha_dl[0] <= alpha;
    beta_dl[0]  <= beta;
    for (int i = 1; i < DLY; i++) begin
      alpha_dl[i] <= alpha_dl[i-1];
      beta_dl[i]  <= beta_dl[i-1];
    end
  end

  assign done_o           = valid_q[LAT-1];
  assign air_speed_o      = speed_q;
  assign attack_angle_o   = alpha_dl[DLY-1];
  assign sideslip_angle_o = beta_dl[DLY-1];

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined block");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("transfer lost in the pipeline");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> valid_q[LAT-2] || $past(valid_q[LAT-2]))
    else $error("result strobe without a matching transfer");

endmodule

// ----- rtl/adt_cordic_cell.sv -----
`timescale 1ns / 1ps
module adt_cordic_cell #(
  parameter int W = 34,
  parameter int SIDE_W = 1,
  parameter int IDX = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                       clk_i,
  input  logic signed [W-1:0]        x_i,
  input  logic signed [W-1:0]        y_i,
  input  logic signed [adt_pkg::ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic signed [W-1:0]        x_o,
  output logic signed [W-1:0]        y_o,
  output logic signed [adt_pkg::ZW-1:0] z_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic signed [W-1:0] dx, dy;
  logic                up;
  logic signed [W-1:0] x_d, y_d, x_q, y_q;
  logic signed [adt_pkg::ZW-1:0] z_d, z_q;
  logic [SIDE_W-1:0]   side_q;

  // one micro-rotation; direction from the angle or from the sign of y
  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    up = VECTORING ? y_i[W-1] : ~z_i[adt_pkg::ZW-1];
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - adt_pkg::ATAN_TAB[IDX];
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + adt_pkg::ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// ----- rtl/adt_rotator.sv -----
`timescale 1ns / 1ps
module adt_rotator #(
  parameter int N = 16,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic signed [adt_pkg::VW-1:0] x_i,
  input  logic signed [adt_pkg::VW-1:0] y_i,
  input  logic [31:0]                   ang_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic signed [adt_pkg::VW-1:0] x_o,
  output logic signed [adt_pkg::VW-1:0] y_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int W = adt_pkg::VW;
  localparam int ZW = adt_pkg::ZW;

  logic signed [ZW-1:0] z_in;
  logic signed [W-1:0]  x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic [SIDE_W-1:0]    side_q;

  logic signed [W-1:0]  x_s [0:N];
  logic signed [W-1:0]  y_s [0:N];
  logic signed [ZW-1:0] z_s [0:N];
  logic [SIDE_W-1:0]    side_s [0:N];

  logic signed [W+31:0] prod_x, prod_y;
  logic signed [W-1:0]  xo_q, yo_q;
  logic [SIDE_W-1:0]    sideo_q;

  // quarter-turn pre-reduction
  always_comb begin
    z_in = ZW'($signed(ang_i));
    x_d  = x_i;
    y_d  = y_i;
    z_d  = z_in;
    if (z_in > adt_pkg::QUARTER) begin
      x_d = -y_i;
      y_d = x_i;
      z_d = z_in - adt_pkg::QUARTER;
    end else if (z_in < -adt_pkg::QUARTER) begin
      x_d = y_i;
      y_d = -x_i;
      z_d = z_in + adt_pkg::QUARTER;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign x_s[0]    = x_q;
  assign y_s[0]    = y_q;
  assign z_s[0]    = z_q;
  assign side_s[0] = side_q;

  // chain of micro-rotation cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    adt_cordic_cell #(
      .W(W), .SIDE_W(SIDE_W), .IDX(i), .VECTORING(1'b0)
    ) u_cell (
      .clk_i  (clk_i),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .side_i (side_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  // gain removal, floor shift by 30
  assign prod_x = (W+32)'(x_s[N]) * (W+32)'(adt_pkg::INV_GAIN);
  assign prod_y = (W+32)'(y_s[N]) * (W+32)'(adt_pkg::INV_GAIN);

  always_ff @(posedge clk_i) begin
    xo_q    <= prod_x[W+29:30];
    yo_q    <= prod_y[W+29:30];
    sideo_q <= side_s[N];
  end

  assign x_o    = xo_q;
  assign y_o    = yo_q;
  assign side_o = sideo_q;

endmodule

// ----- rtl/adt_atan2.sv -----
`timescale 1ns / 1ps
module adt_atan2 #(
  parameter int N = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [adt_pkg::VW-1:0] y_i,
  input  logic signed [adt_pkg::VW-1:0] x_i,
  output logic signed [15:0]            ang_o
);

  localparam int W = adt_pkg::VW + 2;
  localparam int ZW = adt_pkg::ZW;
  localparam int FW = $bits(adt_pkg::vflags_t);

  logic signed [W-1:0]  xe, ye, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  adt_pkg::vflags_t     fl_d, fl_q, fl_n;

  logic signed [W-1:0]  x_s [0:N];
  logic signed [W-1:0]  y_s [0:N];
  logic signed [ZW-1:0] z_s [0:N];
  logic [FW-1:0]        f_s [0:N];

  logic signed [ZW-1:0] z_rnd;
  logic signed [15:0]   ang_d, ang_q;
  logic                 zero_q;

  // left half plane folded by a quarter turn; zero x flagged
  always_comb begin
    xe = W'(x_i);
    ye = W'(y_i);
    fl_d.zero_x = (x_i == '0);
    fl_d.y_pos  = (y_i > 0);
    fl_d.y_neg  = y_i[adt_pkg::VW-1];
    x_d = xe;
    y_d = ye;
    z_d = '0;
    if (x_i[adt_pkg::VW-1]) begin
      if (!y_i[adt_pkg::VW-1]) begin
        x_d = ye;
        y_d = -xe;
        z_d = adt_pkg::QUARTER;
      end else begin
        x_d = -ye;
        y_d = xe;
        z_d = -adt_pkg::QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    fl_q <= fl_d;
  end

  assign x_s[0] = x_q;
  assign y_s[0] = y_q;
  assign z_s[0] = z_q;
  assign f_s[0] = fl_q;

  // chain of vectoring cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    adt_cordic_cell #(
      .W(W), .SIDE_W(FW), .IDX(i), .VECTORING(1'b1)
    ) u_cell (
      .clk_i  (clk_i),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .side_i (f_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .side_o (f_s[i+1])
    );
  end

  // round to 1/65536 turn, or the fixed answer for zero x
  always_comb begin
    fl_n  = f_s[N];
    z_rnd = z_s[N] + ZW'(64'sd32768);
    ang_d = z_rnd[31:16];
    if (fl_n.zero_x) begin
      if (fl_n.y_pos) begin
        ang_d = 16'sd16384;
      end else if (fl_n.y_neg) begin
        ang_d = -16'sd16384;
      end else begin
        ang_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q  <= ang_d;
    zero_q <= fl_n.zero_x;
  end

  assign ang_o = ang_q;

  a_zero_x_ang : assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q |-> (ang_q == 16'sd0 || ang_q == 16'sd16384 || ang_q == -16'sd16384))
    else $error("zero forward speed gave an angle off the axes");

endmodule

// ----- rtl/adt_sqrt_cell.sv -----
`timescale 1ns / 1ps
module adt_sqrt_cell #(
  parameter int K = 0
) (
  input  logic        clk_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] res_i,
  output logic [63:0] rem_o,
  output logic [63:0] res_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

  logic [63:0] trial, rem_d, res_d, rem_q, res_q;

  // one restoring step of the digit-by-digit root
  always_comb begin
    trial = res_i + BIT;
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign rem_o = rem_q;
  assign res_o = res_q;

endmodule

// ----- dv/adt_checker.sv -----
`timescale 1ns / 1ps
module adt_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [19:0] vel_forward_i,
  input  logic signed [19:0] vel_left_i,
  input  logic signed [19:0] vel_up_i,
  input  logic signed [19:0] wind_north_i,
  input  logic signed [19:0] wind_west_i,
  input  logic signed [19:0] wind_vertical_i,
  input  logic               done_o,
  input  logic [20:0]        air_speed_o,
  input  logic signed [15:0] attack_angle_o,
  input  logic signed [15:0] sideslip_angle_o,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [20:0]        speed;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } air_data_t;

  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1073741824;

  // atan(2^-i) in 2^-32 turn
  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  air_data_t air_data_q[$];

  // gain-compensated CORDIC rotation of (x, y) by a, in 2^-32 turn
  function automatic void cordic_rotate(inout longint x, inout longint y,
                                        input logic [31:0] a);
    longint z, px, py, t, dx, dy;
    z  = longint'(signed'(a));
    px = x;
    py = y;
    if (z > QUARTER_TURN) begin
      t = px; px = -py; py = t; z -= QUARTER_TURN;
    end else if (z < -QUARTER_TURN) begin
      t = px; px = py; py = -t; z += QUARTER_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (z >= 0) begin
        px -= dx; py += dy; z -= ARCTAN[i];
      end else begin
        px += dx; py -= dy; z += ARCTAN[i];
      end
    end
    x = (px * INV_GAIN_Q30) >>> 30;
    y = (py * INV_GAIN_Q30) >>> 30;
  endfunction

  // atan2(y, x) as a 16-bit binary angle
  function automatic logic [15:0] vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0) begin
      if (y > 0) return 16'sd16384;
      if (y < 0) return -16'sd16384;
      return '0;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    return 16'((z + 32768) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic air_data_t predict_air_data();
    longint wx, wy, wz, u, v, w;
    longint unsigned sum, mag;
    air_data_t r;
    wx = longint'(wind_north_i) * 256;
    wy = longint'(wind_west_i) * 256;
    wz = longint'(wind_vertical_i) * 256;
    cordic_rotate(wx, wy, 32'd0 - {yaw_angle_i, 16'd0});
    cordic_rotate(wx, wz, {pitch_angle_i, 16'd0});
    cordic_rotate(wy, wz, 32'd0 - {roll_angle_i, 16'd0});
    // FLU to FRD
    u = longint'(vel_forward_i) * 256 - wx;
    v = -(longint'(vel_left_i) * 256 - wy);
    w = -(longint'(vel_up_i) * 256 - wz);
    sum = longint'(u * u) + longint'(v * v) + longint'(w * w);
    mag = (int_sqrt(sum) + 128) >> 8;
    if (mag > 2097151) mag = 2097151;
    r.speed = 21'(mag);
    r.alpha = vector_angle(w, u);
    r.beta  = vector_angle(v, u);
    return r;
  endfunction

  assign pending_o = air_data_q.size();

  // predict on each input transfer, compare on each result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    air_data_t exp_r;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (start_i && !busy_o) air_data_q.push_back(predict_air_data());
      if (done_o) begin
        if (air_data_q.size() == 0) begin
          $error("air_data: result with none expected");
          errs++;
        end else begin
          exp_r = air_data_q.pop_front();
          if (air_speed_o !== exp_r.speed) begin
            $error("air_speed: expected %0d, got %0d", exp_r.speed, air_speed_o);
            errs++;
          end
          if (attack_angle_o !== exp_r.alpha) begin
            $error("attack_angle: expected %0d, got %0d", exp_r.alpha,
                   attack_angle_o);
            errs++;
          end
          if (sideslip_angle_o !== exp_r.beta) begin
            $error("sideslip_angle: expected %0d, got %0d", exp_r.beta,
                   sideslip_angle_o);
            errs++;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY  = 3 * 16 + 42;
  localparam int WD_LIMIT = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  logic signed [19:0] vel_forward_i = '0, vel_left_i = '0, vel_up_i = '0;
  logic signed [19:0] wind_north_i = '0, wind_west_i = '0, wind_vertical_i = '0;
  logic               done_o;
  logic [20:0]        air_speed_o;
  logic signed [15:0] attack_angle_o, sideslip_angle_o;
  int                 fail_cnt, pending, idle_cycles;
  logic               busy_s;
  bit                 timed_out = 1'b0;

  always #6 clk_i = ~clk_i;

  air_data_triplet #(.CORDIC_STAGES(16)) u_top (.*);

  adt_checker #(.CORDIC_STAGES(16)) u_checker (
    .*, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // busy sampled mid-cycle so the edge check does not race the block
  always @(negedge clk_i) busy_s <= busy_o;

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WD_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  int  gap_max = 15;

  task automatic send(logic signed [15:0] r, p, y,
                      logic signed [19:0] vf, vl, vu, wn, ww, wv);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    roll_angle_i  <= r;  pitch_angle_i <= p;  yaw_angle_i <= y;
    vel_forward_i <= vf; vel_left_i    <= vl; vel_up_i    <= vu;
    wind_north_i  <= wn; wind_west_i   <= ww; wind_vertical_i <= wv;
    do @(posedge clk_i); while (busy_s);
  endtask

  function automatic logic signed [19:0] rnd_vel(int mode);
    case (mode)
      0:       return 20'($urandom);
      1:       return 20'(int'($urandom_range(0, 4000)) - 2000);
      default: return '0;
    endcase
  endfunction

  initial begin
    logic signed [15:0] a_max, a_min;
    logic signed [19:0] v_max, v_min;
    int mode;
    a_max = 16'sh7fff; a_min = 16'sh8000;
    v_max = 20'sh7ffff; v_min = 20'sh80000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero flow, axis-aligned flow, field extremes
    send(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(0, 0, 0, 0, 1000, 0, 0, 0, 0);
    send(0, 0, 0, 0, -1000, 500, 0, 0, 0);
    send(0, 0, 0, 0, 0, -700, 0, 0, 0);
    send(0, 0, 0, -3000, 0, 0, 0, 0, 0);
    send(0, 0, 0, 3000, 0, 0, 0, 0, 0);
    send(0, 0, 0, 0, 0, 0, 3000, 0, 0);
    send(16384, -16384, 16384, 100, 200, 300, 400, 500, 600);
    send(a_min, a_min, a_min, v_min, v_min, v_min, v_max, v_max, v_max);
    send(a_max, a_max, a_max, v_max, v_max, v_max, v_min, v_min, v_min);
    send(a_min, a_max, 0, v_max, v_min, v_max, v_max, v_min, v_max);
    send(-16384, 16384, -16384, v_min, v_max, v_min, v_min, v_max, v_min);
    send(16385, -16385, a_min, 0, 0, 0, v_max, v_max, v_max);
    send(0, 0, 0, v_max, v_max, v_max, v_min, v_min, v_min);
    send(-1, 1, -1, -1, 1, -1, 1, -1, 1);

    // random: alternating stretches with and without gaps
    for (int n = 0; n < 900; n++) begin
      if (n % 150 == 0) gap_max = (n % 300 == 0) ? 15 : 0;
      mode = $urandom_range(0, 3);
      send(16'($urandom), 16'($urandom), 16'($urandom),
           ($urandom_range(0, 7) == 0) ? '0 : rnd_vel(mode),
           rnd_vel(mode), rnd_vel(mode),
           ($urandom_range(0, 3) == 0) ? '0 : rnd_vel(mode),
           rnd_vel(mode), rnd_vel(mode));
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/adt_pkg.sv
rtl/adt_cordic_cell.sv
rtl/adt_rotator.sv
rtl/adt_atan2.sv
rtl/adt_sqrt_cell.sv
rtl/air_data_triplet.sv
dv/adt_checker.sv
dv/tb_top.sv
